### rtl/apc_pkg.sv
// Shared types and constants of the alignment pileup counter.
package apc_pkg;

	localparam int WP_W       = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_GAP_CODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_LENGTH = 2'd1;

	localparam logic [7:0]      GAP_CODE_RESET    = 8'd45;
	localparam logic [WP_W-1:0] READ_LENGTH_RESET = 17'd65536;

	typedef enum logic [1:0] {
		OP_COLUMN = 2'd0,
		OP_START  = 2'd1,
		OP_READ   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_RANGE    = 2'd1,
		STATUS_MISMATCH = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CLASS_MATCH     = 2'd0,
		CLASS_INSERT    = 2'd1,
		CLASS_UNDECIDED = 2'd2
	} class_t;

	typedef enum logic [2:0] {
		K_NONE,
		K_MATCH,
		K_INSERT,
		K_DELETE,
		K_READ
	} kind_t;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_EXEC,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] position;
		logic [7:0]  query_symbol;
		logic [7:0]  subject_symbol;
	} in_item_t;

	typedef struct packed {
		logic [7:0] match_count;
		logic [7:0] insert_count;
		logic [7:0] delete_count;
		logic [7:0] base_symbol;
		logic [1:0] coverage_class;
		logic       delete_heavy;
		logic [1:0] status;
	} out_item_t;

endpackage

### rtl/apc_if.sv
// Valid/ready stream interfaces for input items and result items.
interface apc_req_if;
	logic              valid;
	logic              ready;
	apc_pkg::in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

interface apc_rsp_if;
	logic               valid;
	logic               ready;
	apc_pkg::out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

### rtl/alignment_pileup_counter.sv
// Pileup count table: per-position match, insert and delete counters in one memory.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-------------------------------------------
//   req      | in  | valid/ready   | operation, position, query/subject symbol
//   rsp      | out | valid/ready   | counts, base, class, delete flag, status
//   cfg      | in  | write enable  | register index, write data
//
// In the accept cycle of a column, start or read item the table read is issued;
// in the cycle after it the updated entry is written back and the result formed.
// The table memory has a registered read port, and the next item is taken only
// after the write-back, so no read can see a stale entry.
// A clear item is accepted, the clearing pass then writes every table entry to
// zero, and its result is formed after that pass. After reset the same clearing
// pass runs before the first item is taken.
// A stalled result beat sits in the output register; the block takes the next item
// meanwhile and parks a further result in a hold register until the output frees,
// and takes no input while that hold register is occupied.
module alignment_pileup_counter #(
	parameter int TABLE_DEPTH = 65536,
	parameter int COUNT_WIDTH = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [apc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [apc_pkg::CFG_DATA_W-1:0]   cfg_data,
	apc_req_if.sink                          req,
	apc_rsp_if.source                        rsp
);

	localparam int CW   = COUNT_WIDTH;
	localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int LW   = (AW + 1 > apc_pkg::WP_W) ? AW + 1 : apc_pkg::WP_W;
	localparam int CMPW = CW + 5;
	localparam logic [LW-1:0] DEPTH_L = LW'(TABLE_DEPTH);
	localparam logic [AW-1:0] LAST_A  = AW'(TABLE_DEPTH - 1);

	// One table entry holds all four per-position values.
	typedef struct packed {
		logic [CW-1:0] m;
		logic [CW-1:0] ins;
		logic [CW-1:0] del;
		logic [7:0]    base;
	} entry_t;

	entry_t mem [TABLE_DEPTH];
	entry_t rd_q;
	logic   mem_we;
	logic [AW-1:0] mem_wa;
	entry_t mem_wd;
	logic [AW-1:0] rd_addr;

	apc_pkg::state_t state_q, state_d;
	logic [AW-1:0]   sweep_q;
	logic            reply_q;

	logic [7:0]                gap_q;
	logic [apc_pkg::WP_W-1:0]  read_length_q;
	logic [apc_pkg::WP_W-1:0]  wp_q, wp_d;
	logic                      run_q, run_d;

	apc_pkg::kind_t    kind_q, acc_kind;
	apc_pkg::status_t  status_q, acc_status;
	logic [AW-1:0]     wa_q;
	logic [7:0]        subj_q;

	apc_pkg::out_item_t out_q, hold_q, res;
	logic               out_valid_q;
	logic               out_free;
	logic               accept;

	logic [LW-1:0] lim, rl_ext, wp_ext, wpm1_ext, pos_ext;
	logic [apc_pkg::WP_W-1:0] wpm1;
	logic [7:0] q_sym, s_sym;

	logic [CMPW-1:0] m5, i5, d10, s4;
	entry_t upd;

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
		sat_inc = (c == '1) ? c : c + 1'b1;
	endfunction

	function automatic logic [7:0] clip8(input logic [CW-1:0] v);
		clip8 = (32'(v) > 32'd255) ? 8'hFF : 8'(v);
	endfunction

	// The usable limit is the smaller of the read length and the table depth.
	always_comb begin
		rl_ext   = LW'(read_length_q);
		lim      = (rl_ext > DEPTH_L) ? DEPTH_L : rl_ext;
		wp_ext   = LW'(wp_q);
		wpm1     = wp_q - 1'b1;
		wpm1_ext = LW'(wpm1);
		pos_ext  = LW'(req.item.position);
	end

	assign req.ready = (state_q == apc_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.item  = out_q;

	// Decode of the item being accepted: what it does to the table, the write
	// position and the delete run, and the status it will report.
	always_comb begin
		q_sym      = req.item.query_symbol;
		s_sym      = req.item.subject_symbol;
		acc_kind   = apc_pkg::K_NONE;
		acc_status = apc_pkg::STATUS_OK;
		rd_addr    = AW'(wp_ext);
		wp_d       = wp_q;
		run_d      = run_q;
		case (apc_pkg::op_t'(req.item.operation))
			apc_pkg::OP_COLUMN: begin
				if (run_q && s_sym == gap_q) begin
					// Subject gaps right after a delete are swallowed.
					acc_kind = apc_pkg::K_NONE;
				end else begin
					run_d = 1'b0;
					if (q_sym == gap_q && s_sym == gap_q) begin
						acc_kind = apc_pkg::K_NONE;
					end else if (q_sym == s_sym || q_sym == gap_q) begin
						if (wp_ext >= lim) begin
							acc_status = apc_pkg::STATUS_RANGE;
						end else begin
							acc_kind = (q_sym == s_sym) ? apc_pkg::K_MATCH
							                            : apc_pkg::K_INSERT;
							wp_d     = wp_q + 1'b1;
						end
					end else begin
						// A delete, or a mismatch handled as one, lands on the
						// position before the write position.
						run_d   = 1'b1;
						rd_addr = AW'(wpm1_ext);
						if (wp_q == '0 || wpm1_ext >= lim) begin
							acc_status = apc_pkg::STATUS_RANGE;
						end else begin
							acc_kind   = apc_pkg::K_DELETE;
							acc_status = (s_sym == gap_q) ? apc_pkg::STATUS_OK
							                              : apc_pkg::STATUS_MISMATCH;
						end
					end
				end
			end
			apc_pkg::OP_START: begin
				wp_d  = apc_pkg::WP_W'(req.item.position);
				run_d = 1'b0;
				if (pos_ext >= lim) begin
					acc_status = apc_pkg::STATUS_RANGE;
				end
			end
			apc_pkg::OP_READ: begin
				rd_addr = AW'(pos_ext);
				if (pos_ext >= lim) begin
					acc_status = apc_pkg::STATUS_RANGE;
				end else begin
					acc_kind = apc_pkg::K_READ;
				end
			end
			default: begin
				acc_kind = apc_pkg::K_NONE;
			end
		endcase
	end

	// Update of the entry read for this item, and the result beat. The class
	// tests compare 5*(x+1) against 4*(match+insert), which is the same as
	// comparing x against floor(4*(match+insert)/5).
	always_comb begin
		upd    = rd_q;
		mem_we = 1'b0;
		mem_wa = wa_q;
		mem_wd = rd_q;
		s4  = (CMPW'(rd_q.m) + CMPW'(rd_q.ins)) << 2;
		m5  = CMPW'(rd_q.m) * CMPW'(5) + CMPW'(5);
		i5  = CMPW'(rd_q.ins) * CMPW'(5) + CMPW'(5);
		d10 = CMPW'(rd_q.del) * CMPW'(10) + CMPW'(5);
		res = '0;
		res.status = status_q;
		case (kind_q)
			apc_pkg::K_MATCH: begin
				upd.m    = sat_inc(rd_q.m);
				upd.base = subj_q;
			end
			apc_pkg::K_INSERT: upd.ins = sat_inc(rd_q.ins);
			apc_pkg::K_DELETE: upd.del = sat_inc(rd_q.del);
			apc_pkg::K_READ: begin
				res.match_count  = clip8(rd_q.m);
				res.insert_count = clip8(rd_q.ins);
				res.delete_count = clip8(rd_q.del);
				res.base_symbol  = rd_q.base;
				if (m5 > s4) begin
					res.coverage_class = apc_pkg::CLASS_MATCH;
				end else if (i5 > s4) begin
					res.coverage_class = apc_pkg::CLASS_INSERT;
				end else begin
					res.coverage_class = apc_pkg::CLASS_UNDECIDED;
				end
				res.delete_heavy = (d10 > s4);
			end
			default: ;
		endcase
		if (state_q == apc_pkg::ST_SWEEP) begin
			mem_we = 1'b1;
			mem_wa = sweep_q;
			mem_wd = '0;
		end else if (state_q == apc_pkg::ST_EXEC && (kind_q == apc_pkg::K_MATCH ||
		             kind_q == apc_pkg::K_INSERT || kind_q == apc_pkg::K_DELETE)) begin
			mem_we = 1'b1;
			mem_wd = upd;
		end
	end

	// Table memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[rd_addr];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			apc_pkg::ST_SWEEP: begin
				if (sweep_q == LAST_A) begin
					state_d = reply_q ? apc_pkg::ST_EXEC : apc_pkg::ST_IDLE;
				end
			end
			apc_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (apc_pkg::op_t'(req.item.operation) == apc_pkg::OP_CLEAR) ?
					          apc_pkg::ST_SWEEP : apc_pkg::ST_EXEC;
				end
			end
			apc_pkg::ST_EXEC: state_d = out_free ? apc_pkg::ST_IDLE : apc_pkg::ST_HOLD;
			apc_pkg::ST_HOLD: begin
				if (out_free) begin
					state_d = apc_pkg::ST_IDLE;
				end
			end
			default: state_d = apc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= apc_pkg::ST_SWEEP;
			sweep_q       <= '0;
			reply_q       <= 1'b0;
			gap_q         <= apc_pkg::GAP_CODE_RESET;
			read_length_q <= apc_pkg::READ_LENGTH_RESET;
			wp_q          <= '0;
			run_q         <= 1'b0;
			kind_q        <= apc_pkg::K_NONE;
			status_q      <= apc_pkg::STATUS_OK;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == apc_pkg::CFG_GAP_CODE) begin
					gap_q <= cfg_data[7:0];
				end else if (cfg_index == apc_pkg::CFG_READ_LENGTH) begin
					read_length_q <= cfg_data;
				end
			end
			if (state_q == apc_pkg::ST_SWEEP) begin
				sweep_q <= (sweep_q == LAST_A) ? '0 : sweep_q + 1'b1;
			end
			if (accept) begin
				wp_q     <= wp_d;
				run_q    <= run_d;
				kind_q   <= acc_kind;
				status_q <= acc_status;
				reply_q  <= (apc_pkg::op_t'(req.item.operation) == apc_pkg::OP_CLEAR);
			end
			if ((state_q == apc_pkg::ST_EXEC || state_q == apc_pkg::ST_HOLD) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wa_q   <= rd_addr;
			subj_q <= req.item.subject_symbol;
		end
		if (state_q == apc_pkg::ST_EXEC) begin
			if (out_free) begin
				out_q <= res;
			end else begin
				hold_q <= res;
			end
		end else if (state_q == apc_pkg::ST_HOLD && out_free) begin
			out_q <= hold_q;
		end
	end

`ifndef SYNTHESIS
	// The table is only written by the clearing pass or the write-back cycle.
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == apc_pkg::ST_IDLE || state_q == apc_pkg::ST_HOLD) |-> !mem_we)
		else $error("table written outside sweep or write-back");

	// Every accepted item other than a clear reaches the write-back state in the next cycle.
	a_exec_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && apc_pkg::op_t'(req.item.operation) != apc_pkg::OP_CLEAR)
		|=> state_q == apc_pkg::ST_EXEC)
		else $error("accepted item did not reach write-back");

	// A result is parked only while the output register is occupied.
	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == apc_pkg::ST_HOLD) |-> out_valid_q)
		else $error("result held with an empty output register");
`endif

endmodule
